[hdl/bfst_pkg.sv]
// Shared types, codes and sizing for the best-fit free space table.
package bfst_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  localparam logic [1:0] ReqFresh  = 2'd0;
  localparam logic [1:0] ReqLoaded = 2'd1;
  localparam logic [1:0] ReqAlloc  = 2'd2;
  localparam logic [1:0] ReqClear  = 2'd3;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StGranted  = 3'd1;
  localparam logic [2:0] StNoFit    = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StCleared  = 3'd4;

  typedef enum logic {
    CmpFit,
    CmpOrder
  } cmp_mode_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] slot_position;
    logic [15:0] slot_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_position;
    logic [15:0] granted_size;
  } resp_t;

  typedef struct packed {
    logic [31:0] position;
    logic [15:0] size;
    logic [15:0] stamp;
  } entry_t;

  typedef struct packed {
    cmp_mode_e   mode;
    logic [15:0] key_size;
    logic [15:0] key_stamp;
    logic [15:0] ent_size;
    logic [15:0] ent_stamp;
  } cmp_req_t;

endpackage

[hdl/best_fit_free_space_table.sv]
// Best-fit free space table: top level with request sequencer.
//
// Usage: requests enter on in_valid_i/in_ready_o as one beat of req_t
// (release fresh, release loaded, allocate, clear); every request returns
// exactly one resp_t beat on out_valid_o/out_ready_i.
// The table is kept sorted by size, then by signed stamp (larger first).
// A single compare unit and a one-read/one-write entry memory are walked by
// the sequencer, each entry visited in an address step, then a compare/move step.
// Clear, full-table release and allocate on an empty table go straight to
// the response step; allocate scans entries until a live one fits or the count
// runs out, and release compares entries for its place, shifts the tail up and
// writes the new entry.
// One request is in flight at a time; in_ready_o is high only when idle.
// The result sits in an output register, so the next request is taken while
// the previous result waits; a stalled receiver holds the finished result and
// the sequencer waits in its response step until the register frees up.
// Reset clears the count, live bits, release counter and handshakes at once;
// entry contents stay unwritten and need no clearing pass.
module best_fit_free_space_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bfst_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bfst_pkg::resp_t out_data_o
);

  localparam int unsigned IdxW = bfst_pkg::IdxW;
  localparam int unsigned CntW = bfst_pkg::CntW;

  // sequencer states
  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SARd  = 4'd1;  // allocate: address entry
  localparam logic [3:0] SACmp = 4'd2;  // allocate: test fit
  localparam logic [3:0] SIRd  = 4'd3;  // insert: address entry
  localparam logic [3:0] SICmp = 4'd4;  // insert: test order
  localparam logic [3:0] SSRd  = 4'd5;  // shift: read entry below
  localparam logic [3:0] SSWr  = 4'd6;  // shift: write it one up
  localparam logic [3:0] SIWr  = 4'd7;  // insert: write new entry
  localparam logic [3:0] SResp = 4'd8;  // hand result to output register

  logic [3:0]                      state_q, state_d;
  logic [CntW-1:0]                 idx_q, idx_d;
  logic [CntW-1:0]                 at_q, at_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic [15:0]                     rel_cnt_q, rel_cnt_d;
  logic [bfst_pkg::TableDepth-1:0] live_q, live_d;
  logic [15:0]                     stamp_q, stamp_d;
  bfst_pkg::req_t                  req_q, req_d;
  bfst_pkg::resp_t                 res_q, res_d;
  logic                            out_valid_q, out_valid_d;
  bfst_pkg::resp_t                 out_data_q, out_data_d;

  logic [CntW-1:0]   idx_m1, idx_p1;
  logic [15:0]       stamp_ld;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  bfst_pkg::entry_t  mem_wdata, mem_rdata;
  bfst_pkg::cmp_req_t cmp_req;
  logic              cmp_hit;

  assign idx_m1   = idx_q - 1'b1;
  assign idx_p1   = idx_q + 1'b1;
  // loaded slots take minus the new count, wrapped to 16 bits
  assign stamp_ld = 16'd0 - 16'(count_q) - 16'd1;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  bfst_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    cmp_req.mode      = (state_q == SACmp) ? bfst_pkg::CmpFit : bfst_pkg::CmpOrder;
    cmp_req.key_size  = req_q.slot_size;
    cmp_req.key_stamp = stamp_q;
    cmp_req.ent_size  = mem_rdata.size;
    cmp_req.ent_stamp = mem_rdata.stamp;
  end

  bfst_cmp u_cmp (
    .cmp_i (cmp_req),
    .hit_o (cmp_hit)
  );

  // memory port steering
  always_comb begin
    mem_raddr = idx_q[IdxW-1:0];
    if (state_q == SSRd) begin
      mem_raddr = idx_m1[IdxW-1:0];
    end
    mem_we    = 1'b0;
    mem_waddr = idx_q[IdxW-1:0];
    mem_wdata = mem_rdata;
    if (state_q == SSWr) begin
      mem_we = 1'b1;
    end else if (state_q == SIWr) begin
      mem_we             = 1'b1;
      mem_waddr          = at_q[IdxW-1:0];
      mem_wdata.position = req_q.slot_position;
      mem_wdata.size     = req_q.slot_size;
      mem_wdata.stamp    = stamp_q;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    at_d        = at_q;
    count_d     = count_q;
    rel_cnt_d   = rel_cnt_q;
    live_d      = live_q;
    stamp_d     = stamp_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // drop the held result once the receiver takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          idx_d = '0;
          res_d = '0;
          case (in_data_i.req_type)
            bfst_pkg::ReqClear: begin
              live_d       = '0;
              count_d      = '0;
              res_d.status = bfst_pkg::StCleared;
              state_d      = SResp;
            end
            bfst_pkg::ReqAlloc: begin
              if (count_q == '0) begin
                res_d.status       = bfst_pkg::StNoFit;
                res_d.granted_size = in_data_i.slot_size;
                state_d            = SResp;
              end else begin
                state_d = SARd;
              end
            end
            default: begin
              if (count_q == CntW'(bfst_pkg::TableDepth)) begin
                res_d.status = bfst_pkg::StFull;
                state_d      = SResp;
              end else begin
                if (in_data_i.req_type == bfst_pkg::ReqFresh) begin
                  rel_cnt_d = rel_cnt_q + 16'd1;
                  stamp_d   = rel_cnt_q + 16'd1;
                end else begin
                  stamp_d = stamp_ld;
                end
                if (count_q == '0) begin
                  at_d    = '0;
                  state_d = SIWr;
                end else begin
                  state_d = SIRd;
                end
              end
            end
          endcase
        end
      end
      SARd: begin
        state_d = SACmp;
      end
      SACmp: begin
        if (cmp_hit && live_q[idx_q[IdxW-1:0]]) begin
          live_d[idx_q[IdxW-1:0]] = 1'b0;
          res_d.status            = bfst_pkg::StGranted;
          res_d.granted_position  = mem_rdata.position;
          res_d.granted_size      = mem_rdata.size;
          state_d                 = SResp;
        end else if (idx_p1 == count_q) begin
          res_d.status       = bfst_pkg::StNoFit;
          res_d.granted_size = req_q.slot_size;
          state_d            = SResp;
        end else begin
          idx_d   = idx_p1;
          state_d = SARd;
        end
      end
      SIRd: begin
        state_d = SICmp;
      end
      SICmp: begin
        if (cmp_hit) begin
          // open a hole at this place: shift the tail up from the top
          at_d    = idx_q;
          idx_d   = count_q;
          state_d = SSRd;
        end else if (idx_p1 == count_q) begin
          at_d    = count_q;
          state_d = SIWr;
        end else begin
          idx_d   = idx_p1;
          state_d = SIRd;
        end
      end
      SSRd: begin
        state_d = SSWr;
      end
      SSWr: begin
        live_d[idx_q[IdxW-1:0]] = live_q[idx_m1[IdxW-1:0]];
        if (idx_m1 == at_q) begin
          state_d = SIWr;
        end else begin
          idx_d   = idx_m1;
          state_d = SSRd;
        end
      end
      SIWr: begin
        live_d[at_q[IdxW-1:0]] = 1'b1;
        count_d                = count_q + 1'b1;
        res_d                  = '0;
        res_d.status           = bfst_pkg::StInserted;
        state_d                = SResp;
      end
      SResp: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      rel_cnt_q   <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rel_cnt_q   <= rel_cnt_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    at_q       <= at_d;
    stamp_q    <= stamp_d;
    req_q      <= req_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTH
  // occupancy never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(bfst_pkg::TableDepth))
    else $error("entry count above table depth");

  // no live entry above the occupied region; the shift and the insert write
  // run one place ahead of the count until the count advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SSRd && state_q != SSWr && state_q != SIWr)
    |-> ((live_q >> count_q) == '0))
    else $error("live bit set beyond entry count");

  // a clear empties the table in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.req_type == bfst_pkg::ReqClear)
    |=> (count_q == '0 && live_q == '0))
    else $error("clear did not empty the table");

  // a result only appears out of the response step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == SResp))
    else $error("result raised outside the response step");
`endif

endmodule

[hdl/bfst_mem.sv]
// Entry storage: one write port, one registered read port.
module bfst_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [bfst_pkg::IdxW-1:0] waddr_i,
  input  bfst_pkg::entry_t          wdata_i,
  input  logic [bfst_pkg::IdxW-1:0] raddr_i,
  output bfst_pkg::entry_t          rdata_o
);

  bfst_pkg::entry_t mem_q [bfst_pkg::TableDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/bfst_cmp.sv]
// Shared compare unit: fit test for allocate, order test for insert.
module bfst_cmp (
  input  bfst_pkg::cmp_req_t cmp_i,
  output logic               hit_o
);

  always_comb begin
    case (cmp_i.mode)
      bfst_pkg::CmpFit: begin
        hit_o = (cmp_i.key_size <= cmp_i.ent_size);
      end
      bfst_pkg::CmpOrder: begin
        // smaller size first; on a tie the larger signed stamp goes first
        if (cmp_i.key_size != cmp_i.ent_size) begin
          hit_o = (cmp_i.key_size < cmp_i.ent_size);
        end else begin
          hit_o = ($signed(cmp_i.key_stamp) > $signed(cmp_i.ent_stamp));
        end
      end
      default: begin
        hit_o = 1'b0;
      end
    endcase
  end

endmodule

[tb/tb_best_fit_free_space_table.sv]
// Self-checking testbench for the best-fit free space table.
module tb_best_fit_free_space_table;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  bfst_pkg::req_t  in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  bfst_pkg::resp_t out_data_o;

  best_fit_free_space_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 10 time unit clock: low half, then high half.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the free space table. Only entries below shadow_count are
  // ever read, so the unwritten contents after reset never matter.
  // ---------------------------------------------------------------------------
  logic [31:0] shadow_pos   [bfst_pkg::TableDepth];
  logic [15:0] shadow_size  [bfst_pkg::TableDepth];
  logic [15:0] shadow_stamp [bfst_pkg::TableDepth];
  logic        shadow_live  [bfst_pkg::TableDepth];
  int          shadow_count;
  logic [15:0] shadow_release_ctr;

  bfst_pkg::resp_t awaited_resp_q [$];   // responses still owed, oldest first

  int  errors;
  int  beats_sent;
  int  n_inserted, n_granted, n_nofit, n_full, n_cleared;
  bit  idling;                 // random gaps on both channels when set
  int  hold_cycles;            // one-shot request for a long receiver hold-off

  // Apply one request to the shadow table and return the response it earns.
  function automatic bfst_pkg::resp_t apply_request(bfst_pkg::req_t r);
    bfst_pkg::resp_t rsp;
    logic [15:0]     stamp;
    int              at;
    rsp = '0;
    case (r.req_type)
      bfst_pkg::ReqClear: begin
        for (int i = 0; i < bfst_pkg::TableDepth; i++) shadow_live[i] = 1'b0;
        shadow_count = 0;
        rsp.status = bfst_pkg::StCleared;
      end
      bfst_pkg::ReqAlloc: begin
        // First live slot in size order that covers the request wins.
        rsp.status = bfst_pkg::StNoFit;
        rsp.granted_size = r.slot_size;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_live[i] && r.slot_size <= shadow_size[i]) begin
            shadow_live[i] = 1'b0;
            rsp.status = bfst_pkg::StGranted;
            rsp.granted_position = shadow_pos[i];
            rsp.granted_size = shadow_size[i];
            break;
          end
        end
      end
      default: begin
        if (shadow_count >= bfst_pkg::TableDepth) begin
          rsp.status = bfst_pkg::StFull;
        end else begin
          if (r.req_type == bfst_pkg::ReqFresh) begin
            shadow_release_ctr = shadow_release_ctr + 16'd1;
            stamp = shadow_release_ctr;
          end else begin
            stamp = 16'(0 - (shadow_count + 1));
          end
          // Size ascending, then larger signed stamp first; full ties go last.
          at = shadow_count;
          for (int i = 0; i < shadow_count; i++) begin
            if (r.slot_size < shadow_size[i] ||
                (r.slot_size == shadow_size[i] &&
                 $signed(stamp) > $signed(shadow_stamp[i]))) begin
              at = i;
              break;
            end
          end
          for (int i = shadow_count; i > at; i--) begin
            shadow_pos[i]   = shadow_pos[i-1];
            shadow_size[i]  = shadow_size[i-1];
            shadow_stamp[i] = shadow_stamp[i-1];
            shadow_live[i]  = shadow_live[i-1];
          end
          shadow_pos[at]   = r.slot_position;
          shadow_size[at]  = r.slot_size;
          shadow_stamp[at] = stamp;
          shadow_live[at]  = 1'b1;
          shadow_count++;
          rsp.status = bfst_pkg::StInserted;
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic bfst_pkg::req_t mk_req(logic [1:0] kind, logic [31:0] pos,
                                            logic [15:0] size);
    bfst_pkg::req_t r;
    r.req_type      = kind;
    r.slot_position = pos;
    r.slot_size     = size;
    return r;
  endfunction

  // Mostly small sizes so allocations hit and miss and sizes collide often.
  function automatic logic [15:0] pick_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 16'hFFFF;
    if (sel == 1) return 16'h0000;
    if (sel < 4)  return 16'($urandom);
    return 16'($urandom_range(0, 31));
  endfunction

  // Well-formed traffic with a tunable clear rate, plus some raw noise.
  function automatic bfst_pkg::req_t pick_request(int clear_pct);
    int             roll;
    bfst_pkg::req_t r;
    roll = $urandom_range(0, 99);
    r.slot_position = $urandom;
    r.slot_size     = pick_size();
    if (roll < 10)                  r.req_type = 2'($urandom);  // noise
    else if (roll < 10 + clear_pct) r.req_type = bfst_pkg::ReqClear;
    else if (roll < 55)             r.req_type = ($urandom_range(0, 3) == 0) ?
                                                 bfst_pkg::ReqLoaded : bfst_pkg::ReqFresh;
    else                            r.req_type = bfst_pkg::ReqAlloc;
    return r;
  endfunction

  // Offer one beat, hold it until accepted, then log what it should return.
  task automatic send_req(bfst_pkg::req_t r);
    int gap;
    if (idling && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_resp_q.push_back(apply_request(r));
    beats_sent++;
  endtask

  // Drop valid and wait until every owed response has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (awaited_resp_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready bursts, plus a long counted hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int n;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
      end else begin
        n = 0;
      end
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Response checker: compare every accepted beat with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bfst_pkg::resp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_resp_q.size() == 0) begin
        $display("%0t: unexpected response beat status=%0d pos=%h size=%h", $time,
                 out_data_o.status, out_data_o.granted_position, out_data_o.granted_size);
        errors++;
      end else begin
        exp_rsp = awaited_resp_q.pop_front();
        if (out_data_o.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_rsp.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.granted_position !== exp_rsp.granted_position) begin
          $display("%0t: granted_position expected %h actual %h", $time,
                   exp_rsp.granted_position, out_data_o.granted_position);
          errors++;
        end
        if (out_data_o.granted_size !== exp_rsp.granted_size) begin
          $display("%0t: granted_size expected %h actual %h", $time,
                   exp_rsp.granted_size, out_data_o.granted_size);
          errors++;
        end
        case (exp_rsp.status)
          bfst_pkg::StInserted: n_inserted++;
          bfst_pkg::StGranted:  n_granted++;
          bfst_pkg::StNoFit:    n_nofit++;
          bfst_pkg::StFull:     n_full++;
          default:              n_cleared++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every request kind, size ties and used-slot skipping.
  task automatic test_directed();
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'h0000));  // empty: no fit
    send_req(mk_req(bfst_pkg::ReqFresh,  32'h0000_0000, 16'h0000));
    send_req(mk_req(bfst_pkg::ReqFresh,  32'hFFFF_FFFF, 16'hFFFF));
    send_req(mk_req(bfst_pkg::ReqFresh,  32'hA5A5_5A5A, 16'd5));
    send_req(mk_req(bfst_pkg::ReqLoaded, 32'h5A5A_A5A5, 16'd5));  // negative stamp after
    send_req(mk_req(bfst_pkg::ReqFresh,  32'h1234_5678, 16'd5));  // newer stamp first
    send_req(mk_req(bfst_pkg::ReqLoaded, 32'hDEAD_BEEF, 16'hFFFF));
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'hFFFF_FFFF, 16'd5));  // equal sizes in order
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'd5));
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'd5));
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'd0));  // zero fits smallest live
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'd0));  // skips used entries
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'hFFFF));
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'hFFFF));
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'hFFFF));  // all used: no fit
    send_req(mk_req(bfst_pkg::ReqClear,  32'hFFFF_FFFF, 16'hFFFF));
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'd1));  // after clear: no fit
    send_req(mk_req(bfst_pkg::ReqLoaded, 32'h0F0F_0F0F, 16'h8000));
    send_req(mk_req(bfst_pkg::ReqAlloc,  32'h0,         16'h7FFF));
    send_req(mk_req(bfst_pkg::ReqClear,  32'h0,         16'h0));
  endtask

  // Fill every place, then hit the full table with both release kinds.
  task automatic test_full_table();
    send_req(mk_req(bfst_pkg::ReqClear, 32'h0, 16'h0));
    for (int i = 0; i < bfst_pkg::TableDepth; i++) begin
      send_req(mk_req(($urandom_range(0, 1) != 0) ? bfst_pkg::ReqFresh : bfst_pkg::ReqLoaded,
                      $urandom, 16'($urandom_range(0, 15))));
    end
    send_req(mk_req(bfst_pkg::ReqFresh,  $urandom, 16'd3));
    send_req(mk_req(bfst_pkg::ReqLoaded, $urandom, 16'd3));
    for (int i = 0; i < 6; i++) begin
      send_req(mk_req(bfst_pkg::ReqAlloc, $urandom, 16'($urandom_range(0, 16))));
    end
    send_req(mk_req(bfst_pkg::ReqFresh, $urandom, 16'd1));  // used slots still take places
    send_req(mk_req(bfst_pkg::ReqClear, 32'h0, 16'h0));
  endtask

  // Hold the receiver off long enough that the input side stalls, then let the
  // sender wait until every owed response has drained.
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_req(pick_request(2));
    wait_drained();
  endtask

  // Bulk random traffic in segments with different clear rates so the table
  // sometimes stays shallow and sometimes runs up to full.
  task automatic test_random(int count);
    int clear_pct;
    clear_pct = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) clear_pct = $urandom_range(0, 2) * 3;
      send_req(pick_request(clear_pct));
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_steady(int count);
    idling = 1'b0;
    for (int i = 0; i < count; i++) send_req(pick_request(2));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    errors       = 0;
    beats_sent   = 0;
    n_inserted   = 0;
    n_granted    = 0;
    n_nofit      = 0;
    n_full       = 0;
    n_cleared    = 0;
    idling       = 1'b1;
    hold_cycles  = 0;
    shadow_count = 0;
    shadow_release_ctr = '0;
    for (int i = 0; i < bfst_pkg::TableDepth; i++) shadow_live[i] = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_backpressure();
    test_random(400);
    test_steady(60);

    // Drain, then give a stray beat time to show up.
    wait_drained();
    repeat (300) @(posedge clk_i);

    $display("Sent %0d requests: %0d inserts, %0d grants, %0d no-fits, %0d full, %0d clears",
             beats_sent, n_inserted, n_granted, n_nofit, n_full, n_cleared);
    $display("Covered size ties, used-slot skipping, a full table and a long output stall");
    if (errors == 0 && awaited_resp_q.size() == 0) begin
      $display("PASS best_fit_free_space_table");
    end else begin
      $display("FAIL best_fit_free_space_table");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("FAIL best_fit_free_space_table");
    $finish;
  end

endmodule

[sim.f]
hdl/bfst_pkg.sv
hdl/bfst_mem.sv
hdl/bfst_cmp.sv
hdl/best_fit_free_space_table.sv
tb/tb_best_fit_free_space_table.sv
